FILE: rtl/selective_repeat_sender_window_macros.svh
// ----------------------------------------------------------------------------
// Selective-repeat sender window: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// same-cycle implication
`define SRSW_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRSW_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Sizes, codes and controller/datapath interface types of the sender window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

	localparam int WINDOW_SLOTS = 16;
	localparam int SEQ_SPACE    = 32;
	localparam int TAG_BITS     = 16;
	localparam int TIME_BITS    = 16;

	localparam int SLOT_W  = $clog2(WINDOW_SLOTS);
	localparam int SEQ_W   = $clog2(SEQ_SPACE);
	localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
	localparam int WORD_W  = 1 + TAG_BITS + TIME_BITS;

	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 2;
	localparam int TAGF_W  = 16;
	localparam int CFG_W   = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd2;

	localparam logic [KIND_W-1:0] KIND_TX     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd2;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_DPORT   = 1'b1;

	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd10;
	localparam logic [CFG_W-1:0] DPORT_RESET   = 16'd0;

	typedef struct packed {
		logic accept;
		logic rd;
		logic step;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic start_scan;
		logic scan_more;
		logic need_emit;
		logic can_push;
		logic pend_v;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/srsw_regs.sv
// ----------------------------------------------------------------------------
// srsw_regs
// APB register file: timeout in ticks and destination port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_regs import srsw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic      [CFG_W-1:0]  timeout_ticks
);

	logic [CFG_W-1:0] timeout_q;
	logic [CFG_W-1:0] dport_q;
	logic             wr;
	logic             idx;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			dport_q   <= DPORT_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_TIMEOUT: timeout_q <= pwdata[CFG_W-1:0];
				REG_DPORT:   dport_q   <= pwdata[CFG_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TIMEOUT: prdata = DATA_W'(timeout_q);
			REG_DPORT:   prdata = DATA_W'(dport_q);
			default:     prdata = '0;
		endcase
	end

	assign timeout_ticks = timeout_q;

endmodule

`default_nettype wire

FILE: rtl/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: takes a word, walks window slots one read and one check at a
// time, then flushes the held result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl import srsw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t st,
	output dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RD    = 4'b0010,
		S_CHK   = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = st.start_scan ? S_RD : S_FLUSH;
				end
			end
			S_RD: begin
				if (st.scan_more) begin
					cmd.rd  = 1'b1;
					state_d = S_CHK;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_CHK: begin
				if (!st.need_emit || st.can_push) begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end
			end
			S_FLUSH: begin
				if (st.can_push) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/srsw_dp.sv
// ----------------------------------------------------------------------------
// srsw_dp
// Window datapath: pointers, ack bits, slot RAM, hold and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsw_dp import srsw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               st,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [SEQ_W-1:0]  seq_num,
	input  wire logic [TAGF_W-1:0] payload_tag,
	input  wire logic              is_last,
	input  wire logic [CFG_W-1:0]  timeout_ticks,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [KIND_W-1:0] kind,
	output logic      [SEQ_W-1:0]  out_seq,
	output logic      [TAGF_W-1:0] out_tag,
	output logic                   out_last,
	output logic                   done_res,
	output logic                   end_of_run
);

	// window state
	logic [SEQ_W-1:0]        head_q;
	logic [SEQ_W-1:0]        tail_q;
	logic [CNT_W-1:0]        used_q;
	logic [WINDOW_SLOTS-1:0] acked_q;
	logic [TIME_BITS-1:0]    now_q;
	logic                    fin_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    tick_q;

	// held result
	logic              pend_v_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [SEQ_W-1:0]  pend_seq_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	logic              pend_last_q;
	logic              pend_done_q;

	// output word
	logic              out_v_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic              out_last_q;
	logic              out_done_q;
	logic              out_eor_q;

	logic [SEQ_W-1:0]    cur_seq;
	logic [SLOT_W-1:0]   cur_x;
	logic [SEQ_W-1:0]    ack_off;
	logic                ack_hit;
	logic                full;
	logic                is_tick;
	logic                is_ack;
	logic                is_offer;
	logic                offer_ok;
	logic [TAG_BITS-1:0] tag_in;
	logic [WORD_W-1:0]   rd_word;
	logic [TIME_BITS-1:0] rd_time;
	logic [TAG_BITS-1:0] rd_tag;
	logic                rd_last;
	logic [TIME_BITS-1:0] age;
	logic                due;
	logic                can_push;
	logic                emit_step;
	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;

	assign is_tick  = (func == FUNC_TICK);
	assign is_ack   = (func == FUNC_ACK);
	assign is_offer = (func == FUNC_OFFER);
	assign tag_in   = TAG_BITS'(payload_tag);
	assign full     = (used_q >= CNT_W'(WINDOW_SLOTS));
	assign offer_ok = cmd.accept & is_offer & ~fin_q & ~full;
	assign ack_off  = SEQ_W'(seq_num - head_q);
	assign ack_hit  = ~fin_q & (32'(ack_off) < 32'(used_q));

	assign cur_seq = tick_q ? SEQ_W'(head_q + SEQ_W'(idx_q)) : head_q;
	assign cur_x   = cur_seq[SLOT_W-1:0];

	assign rd_time = rd_word[TIME_BITS-1:0];
	assign rd_tag  = rd_word[TIME_BITS +: TAG_BITS];
	assign rd_last = rd_word[WORD_W-1];
	assign age     = TIME_BITS'(now_q - rd_time);
	assign due     = ~acked_q[cur_x] & (32'(age) >= 32'(timeout_ticks));

	assign can_push  = ~pend_v_q | ~out_v_q | out_ready;
	assign emit_step = cmd.step & st.need_emit;

	always_comb begin
		st.start_scan = (is_tick & ~fin_q) | (is_ack & ack_hit);
		st.scan_more  = tick_q ? (idx_q < used_q)
		                       : ((used_q != '0) & ~fin_q & acked_q[cur_x]);
		st.need_emit  = tick_q ? due : 1'b1;
		st.can_push   = can_push;
		st.pend_v     = pend_v_q;
	end

	// slot RAM: {last, tag, send time}
	always_comb begin
		ram_we    = offer_ok | (cmd.step & tick_q & due);
		ram_waddr = offer_ok ? tail_q[SLOT_W-1:0] : cur_x;
		ram_wdata = offer_ok ? {is_last, tag_in, now_q} : {rd_last, rd_tag, now_q};
	end

	srsw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WINDOW_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (cur_x),
		.rdata (rd_word)
	);

	// window control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			used_q  <= '0;
			acked_q <= '0;
			now_q   <= '0;
			fin_q   <= 1'b0;
			idx_q   <= '0;
			tick_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				tick_q <= is_tick;
				idx_q  <= '0;
				if (is_tick) begin
					now_q <= now_q + 1'b1;
				end
				if (is_ack && ack_hit) begin
					acked_q[seq_num[SLOT_W-1:0]] <= 1'b1;
				end
				if (offer_ok) begin
					acked_q[tail_q[SLOT_W-1:0]] <= 1'b0;
					tail_q <= tail_q + 1'b1;
					used_q <= used_q + 1'b1;
				end
			end
			if (cmd.step) begin
				if (tick_q) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					head_q <= head_q + 1'b1;
					used_q <= used_q - 1'b1;
					fin_q  <= fin_q | rd_last;
				end
			end
		end
	end

	// held result and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.accept && is_offer) begin
				pend_v_q <= 1'b1;
			end else if (emit_step) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if ((emit_step || cmd.flush) && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_offer) begin
			pend_kind_q <= offer_ok ? KIND_TX : KIND_REFUSE;
			pend_seq_q  <= tail_q;
			pend_tag_q  <= tag_in;
			pend_last_q <= is_last;
			pend_done_q <= offer_ok ? 1'b0 : fin_q;
		end else if (emit_step) begin
			pend_kind_q <= tick_q ? KIND_TX : KIND_REL;
			pend_seq_q  <= cur_seq;
			pend_tag_q  <= rd_tag;
			pend_last_q <= rd_last;
			pend_done_q <= tick_q ? 1'b0 : (fin_q | rd_last);
		end
		if ((emit_step || cmd.flush) && pend_v_q) begin
			out_kind_q <= pend_kind_q;
			out_seq_q  <= pend_seq_q;
			out_tag_q  <= pend_tag_q;
			out_last_q <= pend_last_q;
			out_done_q <= pend_done_q;
			out_eor_q  <= cmd.flush;
		end
	end

	assign out_valid  = out_v_q;
	assign kind       = out_kind_q;
	assign out_seq    = out_seq_q;
	assign out_tag    = TAGF_W'(out_tag_q);
	assign out_last   = out_last_q;
	assign done_res   = out_done_q;
	assign end_of_run = out_eor_q;

endmodule

`default_nettype wire

FILE: rtl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat ARQ window: offers, acks and ticks in,
// transmit, release and refuse words out.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// in        in_valid / in_ready    func, seq_num, payload_tag, is_last
// out       out_valid / out_ready  kind, out_seq, out_tag, out_last,
//                                  done_res, end_of_run
// cfg       APB, pready tied high  paddr, pwdata, prdata
//
// An offer or ignored word goes straight to the flush. A tick walks each used
// slot, an ack each released slot; each costs one slot RAM read and one check.
// A full output word held by out_ready low stalls the slot walk.
// Reset clears pointers, ack bits, time and state; the slot RAM needs no clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_sender_window_macros.svh"

module selective_repeat_sender_window import srsw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [SEQ_W-1:0]  seq_num,
	input  wire logic [TAGF_W-1:0] payload_tag,
	input  wire logic              is_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [KIND_W-1:0] kind,
	output logic      [SEQ_W-1:0]  out_seq,
	output logic      [TAGF_W-1:0] out_tag,
	output logic                   out_last,
	output logic                   done_res,
	output logic                   end_of_run,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	dp_cmd_t          cmd;
	dp_stat_t         st;
	logic [CFG_W-1:0] timeout_ticks;

	assign pready = 1'b1;

	srsw_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.timeout_ticks (timeout_ticks)
	);

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	srsw_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.func          (func),
		.seq_num       (seq_num),
		.payload_tag   (payload_tag),
		.is_last       (is_last),
		.timeout_ticks (timeout_ticks),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_seq       (out_seq),
		.out_tag       (out_tag),
		.out_last      (out_last),
		.done_res      (done_res),
		.end_of_run    (end_of_run)
	);

	`SRSW_ASSERT_IMP(a_idle_no_hold, in_ready, !st.pend_v, "held word left at idle")
	`SRSW_ASSERT_NXT(a_flush_eor, cmd.flush && st.pend_v, out_valid && end_of_run, "flush lost eor")
	`SRSW_ASSERT_NXT(a_offer_word, in_valid && in_ready && func == FUNC_OFFER, st.pend_v, "offer gave no word")

endmodule

`default_nettype wire
